// ===== sv/pps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int TIME_W = 16;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  slot;
    logic [7:0]  task_id;
    logic [7:0]  priority_req;
    logic [15:0] arrival_time;
    logic [15:0] burst_time;
  } item_t;

  typedef struct packed {
    logic [7:0]  running_id;
    logic        idle;
    logic        first_run;
    logic        finished;
    logic [15:0] completion_time;
    logic [15:0] turnaround;
    logic [15:0] waiting;
    logic [15:0] response;
    logic [15:0] time_now;
    logic [15:0] idle_total;
    logic        all_done;
  } result_t;

  // one task table row as held in RAM
  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [15:0] start;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_FINISH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic tick_start;
    logic scan_rd;
    logic update;
    logic finish;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

// ===== sv/priority_preemptive_scheduler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// priority_preemptive_scheduler
// Preemptive priority scheduler over a table of SLOTS tasks, one tick a word.
// ----------------------------------------------------------------------------
// Load, clear and unknown words are taken while idle and give no result. A
// tick word closes the input until its result sits in the output register:
// the task table lives in a single-port-read RAM, and the search for the
// best ready task reads one slot a cycle, followed by a pipeline drain state,
// an update of the served entry and the clocks, a state that forms turnaround
// and response, and the load of the result. A result waiting to be taken holds
// the block before the next word only when a second tick result is ready;
// loads and clears still go in meanwhile.
module priority_preemptive_scheduler #(
  parameter int SLOTS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  pps_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output pps_pkg::result_t result
);

  import pps_pkg::*;

  cmd_t    cmd;
  status_t status;

  pps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .operation  (item.operation),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  pps_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // no word is taken while the table is being scanned
  assert property (@(posedge clk) disable iff (rst) !(item_ready && cmd.scan_rd))
    else $error("word accepted during table scan");

  // a tick closes the input until its result is out
  assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item.operation == OP_TICK) |=> !item_ready)
    else $error("input reopened during tick");

  // loading the result register raises result_valid
  assert property (@(posedge clk) disable iff (rst) cmd.emit |=> result_valid)
    else $error("result not presented after emit");

endmodule
`default_nettype wire

// ===== sv/pps_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/pps_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer: accepts words, walks the table scan, update and result hand-off.
// ----------------------------------------------------------------------------
module pps_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic [1:0]       operation,
  output logic             item_ready,
  input  pps_pkg::status_t status,
  output pps_pkg::cmd_t    cmd
);

  import pps_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = item_valid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && operation == OP_TICK) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_FINISH;
      ST_FINISH: state_next = ST_EMIT;
      ST_EMIT: begin
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready     = (state == ST_IDLE);
    cmd            = '0;
    cmd.load       = accept && operation == OP_LOAD;
    cmd.clear      = accept && operation == OP_CLEAR;
    cmd.tick_start = accept && operation == OP_TICK;
    cmd.scan_rd    = (state == ST_SCAN);
    cmd.update     = (state == ST_UPDATE);
    cmd.finish     = (state == ST_FINISH);
    cmd.emit       = (state == ST_EMIT) && !status.out_busy;
  end

endmodule
`default_nettype wire

// ===== sv/pps_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pps_datapath
// Task table, best-candidate search, time counters and result register.
// ----------------------------------------------------------------------------
module pps_datapath #(
  parameter int SLOTS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  pps_pkg::cmd_t    cmd,
  output pps_pkg::status_t status,
  input  pps_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output pps_pkg::result_t result
);

  import pps_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  // table flags and counters
  logic [SLOTS-1:0]  valid_bits;
  logic [SLOTS-1:0]  done_bits;
  logic [CNT_W-1:0]  pending;
  logic [TIME_W-1:0] cur_time;
  logic [TIME_W-1:0] idle_cnt;

  // scan
  logic [IDX_W-1:0]  scan_idx;
  logic              cmp_en;
  logic [IDX_W-1:0]  cmp_idx;
  logic              best_found;
  logic [IDX_W-1:0]  best_idx;
  entry_t            best;

  // per-tick partial results
  logic [7:0]        res_id;
  logic              res_idle;
  logic              res_first;
  logic              res_fin;
  logic [TIME_W-1:0] res_start;
  logic [TIME_W-1:0] res_tat;
  logic [TIME_W-1:0] res_resp;

  // RAM ports
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  entry_t            rd_data;

  logic              slot_ok;
  logic [IDX_W-1:0]  load_addr;
  logic              old_pend;
  logic              new_pend;
  logic              cand_ready;
  logic              cand_better;
  logic              first;
  logic [TIME_W-1:0] start_eff;
  logic [TIME_W-1:0] rem_new;
  logic [TIME_W-1:0] time_inc;
  logic [TIME_W-1:0] wait_t;

  assign slot_ok   = int'(item.slot) < SLOTS;
  assign load_addr = IDX_W'(item.slot);
  assign old_pend  = valid_bits[load_addr] && !done_bits[load_addr];
  assign new_pend  = (item.burst_time != '0);

  assign first     = (best.remaining == best.burst);
  assign start_eff = first ? cur_time : best.start;
  assign rem_new   = best.remaining - TIME_W'(1);
  assign time_inc  = (cur_time == TIME_MAX) ? cur_time : cur_time + TIME_W'(1);

  // a waiting time cut short by time saturation floors at zero
  assign wait_t = (res_tat >= best.burst) ? res_tat - best.burst : '0;

  assign cand_ready = cmp_en && valid_bits[cmp_idx] && !done_bits[cmp_idx] &&
                      (rd_data.arrival <= cur_time);
  assign cand_better = !best_found || (rd_data.prio > best.prio) ||
                       ((rd_data.prio == best.prio) && (rd_data.arrival < best.arrival));

  assign status.scan_last = (scan_idx == LAST_IDX);
  assign status.out_busy  = result_valid && !result_ready;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = load_addr;
    wr_data = best;
    if (cmd.load) begin
      wr_en             = slot_ok;
      wr_data.id        = item.task_id;
      wr_data.prio      = item.priority_req;
      wr_data.arrival   = item.arrival_time;
      wr_data.burst     = item.burst_time;
      wr_data.remaining = item.burst_time;
      wr_data.start     = '0;
    end else if (cmd.update) begin
      wr_en             = best_found;
      wr_addr           = best_idx;
      wr_data.remaining = rem_new;
      wr_data.start     = start_eff;
    end
  end

  pps_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (SLOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.scan_rd),
    .rd_addr (scan_idx),
    .rd_data (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      valid_bits <= '0;
      done_bits  <= '0;
      pending    <= '0;
      cur_time   <= '0;
      idle_cnt   <= '0;
    end else if (cmd.load) begin
      if (slot_ok) begin
        valid_bits[load_addr] <= 1'b1;
        done_bits[load_addr]  <= !new_pend;
        pending <= pending - CNT_W'(old_pend) + CNT_W'(new_pend);
      end
    end else if (cmd.update) begin
      cur_time <= time_inc;
      if (best_found) begin
        if (rem_new == '0) begin
          done_bits[best_idx] <= 1'b1;
          pending             <= pending - CNT_W'(1);
        end
      end else if (idle_cnt != TIME_MAX) begin
        idle_cnt <= idle_cnt + TIME_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx     <= '0;
      cmp_en       <= 1'b0;
      best_found   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      cmp_en <= cmd.scan_rd;
      if (cmd.tick_start) begin
        scan_idx   <= '0;
        best_found <= 1'b0;
      end else if (cmd.scan_rd) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (cand_ready && cand_better) begin
        best_found <= 1'b1;
      end
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
    if (cand_ready && cand_better) begin
      best     <= rd_data;
      best_idx <= cmp_idx;
    end
    if (cmd.update) begin
      res_idle  <= !best_found;
      res_id    <= best_found ? best.id : '0;
      res_first <= best_found && first;
      res_fin   <= best_found && (rem_new == '0);
      res_start <= start_eff;
    end
    if (cmd.finish) begin
      res_tat  <= cur_time - best.arrival;
      res_resp <= res_start - best.arrival;
    end
    if (cmd.emit) begin
      result.running_id      <= res_id;
      result.idle            <= res_idle;
      result.first_run       <= res_first;
      result.finished        <= res_fin;
      result.completion_time <= res_fin ? cur_time : '0;
      result.turnaround      <= res_fin ? res_tat : '0;
      result.waiting         <= res_fin ? wait_t : '0;
      result.response        <= res_fin ? res_resp : '0;
      result.time_now        <= cur_time;
      result.idle_total      <= idle_cnt;
      result.all_done        <= (pending == '0);
    end
  end

endmodule
`default_nettype wire
